@@ rtl/tfge_pkg.sv @@
// Shared types, constants and the gain table for the track fade envelope.
`timescale 1ns / 1ps

package tfge_pkg;

  // Field and datapath widths
  localparam int unsigned TrackW    = 3;
  localparam int unsigned NumTracks = 8;
  localparam int unsigned RateW     = 16;
  localparam int unsigned MsW       = 16;
  localparam int unsigned CountW    = 10;
  localparam int unsigned VolW      = 11;
  localparam int unsigned PosW      = 22;
  localparam int unsigned SumW      = PosW + 1;
  localparam int unsigned MulAW     = 16;
  localparam int unsigned MulW      = MulAW + SumW;
  localparam int unsigned DivW      = 33;
  localparam int unsigned DivCntW   = 6;

  localparam logic [RateW-1:0] RateReset = 16'd44100;
  localparam logic [PosW-1:0]  LenMax    = 22'h3FFFFF;
  localparam logic [PosW-1:0]  MsDivisor = 22'd1000;
  localparam logic [VolW-1:0]  UnityVol  = 11'd256;
  localparam int               GainMin   = -16;
  localparam int               GainMax   = 8;

  typedef enum logic [1:0] {
    KIND_SET_GAIN = 2'd0,
    KIND_PLAY     = 2'd1,
    KIND_STOP     = 2'd2,
    KIND_ADVANCE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_MUL  = 2'd1,
    ST_DIV  = 2'd2,
    ST_FIN  = 2'd3
  } state_e;

  typedef struct packed {
    kind_e                   kind;
    logic [TrackW-1:0]       track;
    logic signed [7:0]       gain_step;
    logic [MsW-1:0]          fade_ms;
    logic [CountW-1:0]       sample_count;
  } in_item_t;

  typedef struct packed {
    logic [TrackW-1:0] track_echo;
    logic [VolW-1:0]   volume;
    logic              playing;
    logic              fading;
  } out_item_t;

  typedef struct packed {
    logic            play;
    logic            fade;
    logic            fade_out;
    logic [VolW-1:0] base_vol;
    logic [VolW-1:0] cur_vol;
    logic [PosW-1:0] fade_pos;
    logic [PosW-1:0] fade_len;
  } track_state_t;

  localparam track_state_t TrackReset = '{
    play:     1'b0,
    fade:     1'b0,
    fade_out: 1'b0,
    base_vol: UnityVol,
    cur_vol:  UnityVol,
    fade_pos: '0,
    fade_len: '0
  };

  // Clamp a quarter-octave gain and look up its base volume
  function automatic logic [VolW-1:0] gain_volume(logic signed [7:0] gain);
    logic [4:0]      idx;
    logic [VolW-1:0] vol;
    if (gain < GainMin) begin
      idx = 5'd0;
    end else if (gain > GainMax) begin
      idx = 5'(GainMax - GainMin);
    end else begin
      idx = 5'(gain - GainMin);
    end
    case (idx)
      5'd0:    vol = 11'd16;
      5'd1:    vol = 11'd19;
      5'd2:    vol = 11'd22;
      5'd3:    vol = 11'd26;
      5'd4:    vol = 11'd32;
      5'd5:    vol = 11'd38;
      5'd6:    vol = 11'd45;
      5'd7:    vol = 11'd53;
      5'd8:    vol = 11'd64;
      5'd9:    vol = 11'd76;
      5'd10:   vol = 11'd90;
      5'd11:   vol = 11'd107;
      5'd12:   vol = 11'd128;
      5'd13:   vol = 11'd152;
      5'd14:   vol = 11'd181;
      5'd15:   vol = 11'd215;
      5'd16:   vol = 11'd256;
      5'd17:   vol = 11'd304;
      5'd18:   vol = 11'd362;
      5'd19:   vol = 11'd430;
      5'd20:   vol = 11'd512;
      5'd21:   vol = 11'd608;
      5'd22:   vol = 11'd724;
      5'd23:   vol = 11'd861;
      5'd24:   vol = 11'd1024;
      default: vol = UnityVol;
    endcase
    return vol;
  endfunction

endpackage

@@ rtl/track_fade_gain_envelope_core.sv @@
// Top level of the per-track linear fade volume envelope.
// An accepted item passes through the MUL, DIV and FIN sequencer states, and a new
// item waits until the last one is done; the 33-step serial divider sets the pace.
// Input stall stays high from accept until the result enters the output register.
// Reset: all tracks stopped at unity volume, sample rate 44100.
`timescale 1ns / 1ps

module track_fade_gain_envelope_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tfge_pkg::RateW-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  tfge_pkg::in_item_t           in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output tfge_pkg::out_item_t          out_item_o
);

  tfge_pkg::state_e              state_q, state_d;
  logic [tfge_pkg::RateW-1:0]    rate_q;
  tfge_pkg::in_item_t            item_q;
  tfge_pkg::out_item_t           out_q, out_d;
  logic                          out_valid_q, out_valid_d;

  tfge_pkg::track_state_t        rd_state;
  tfge_pkg::track_state_t        nx_state;
  logic                          in_accept;
  logic                          out_free;
  logic                          div_start;
  logic                          div_busy;
  logic                          commit;
  logic [tfge_pkg::DivW-1:0]     quotient;

  logic                          fade_kind;
  logic [tfge_pkg::VolW-1:0]     base_used;
  logic [tfge_pkg::SumW-1:0]     pos_sum;
  logic [tfge_pkg::MulAW-1:0]    mul_a;
  logic [tfge_pkg::SumW-1:0]     mul_b;
  logic [tfge_pkg::MulW-1:0]     product;
  logic [tfge_pkg::PosW-1:0]     divisor;
  logic [tfge_pkg::PosW-1:0]     fade_len;
  logic [tfge_pkg::VolW-1:0]     part;

  assign cfg_ready_o = 1'b1;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Sample rate register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= tfge_pkg::RateReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      rate_q <= cfg_data_i;
    end
  end

  tfge_track_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_idx_i   (item_q.track),
    .rd_state_o (rd_state),
    .wr_en_i    (commit),
    .wr_idx_i   (item_q.track),
    .wr_state_i (nx_state)
  );

  // Pick multiplier and divisor operands: fade length or volume ratio
  always_comb begin
    fade_kind = item_q.kind inside {tfge_pkg::KIND_PLAY, tfge_pkg::KIND_STOP};
    base_used = (item_q.kind == tfge_pkg::KIND_SET_GAIN) ?
                tfge_pkg::gain_volume(item_q.gain_step) : rd_state.base_vol;
    pos_sum   = {1'b0, rd_state.fade_pos} +
                ((item_q.kind == tfge_pkg::KIND_ADVANCE) ?
                 tfge_pkg::SumW'(item_q.sample_count) : '0);
    mul_a     = fade_kind ? rate_q : tfge_pkg::MulAW'(base_used);
    mul_b     = fade_kind ? tfge_pkg::SumW'(item_q.fade_ms) : pos_sum;
    product   = tfge_pkg::MulW'(mul_a) * tfge_pkg::MulW'(mul_b);
    divisor   = fade_kind ? tfge_pkg::MsDivisor : rd_state.fade_len;
  end

  tfge_serial_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (product[tfge_pkg::DivW-1:0]),
    .divisor_i  (divisor),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  // Work out the track's next state from the quotient
  always_comb begin
    fade_len = (quotient > tfge_pkg::DivW'(tfge_pkg::LenMax)) ?
               tfge_pkg::LenMax : quotient[tfge_pkg::PosW-1:0];
    part     = quotient[tfge_pkg::VolW-1:0];
    nx_state = rd_state;
    nx_state.base_vol = base_used;
    case (item_q.kind)
      tfge_pkg::KIND_SET_GAIN, tfge_pkg::KIND_ADVANCE: begin
        if (!rd_state.fade) begin
          nx_state.cur_vol = base_used;
        end else if (pos_sum >= {1'b0, rd_state.fade_len}) begin
          nx_state.fade_pos = (pos_sum > {1'b0, tfge_pkg::LenMax}) ?
                              tfge_pkg::LenMax : pos_sum[tfge_pkg::PosW-1:0];
          nx_state.fade = 1'b0;
          if (rd_state.fade_out) begin
            nx_state.play    = 1'b0;
            nx_state.cur_vol = '0;
          end else begin
            nx_state.cur_vol = base_used;
          end
        end else begin
          nx_state.fade_pos = pos_sum[tfge_pkg::PosW-1:0];
          nx_state.cur_vol  = rd_state.fade_out ? base_used - part : part;
        end
      end
      tfge_pkg::KIND_PLAY: begin
        if (!rd_state.play) begin
          nx_state.play = 1'b1;
          if (fade_len == '0) begin
            nx_state.fade    = 1'b0;
            nx_state.cur_vol = base_used;
          end else begin
            nx_state.fade     = 1'b1;
            nx_state.fade_out = 1'b0;
            nx_state.fade_pos = '0;
            nx_state.fade_len = fade_len;
            nx_state.cur_vol  = '0;
          end
        end
      end
      tfge_pkg::KIND_STOP: begin
        if (rd_state.play) begin
          if (fade_len == '0) begin
            nx_state.play = 1'b0;
            nx_state.fade = 1'b0;
          end else if (!rd_state.fade || !rd_state.fade_out) begin
            nx_state.fade     = 1'b1;
            nx_state.fade_out = 1'b1;
            nx_state.fade_pos = '0;
            nx_state.fade_len = fade_len;
            nx_state.cur_vol  = base_used;
          end
        end
      end
      default: begin
        nx_state = rd_state;
      end
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tfge_pkg::ST_IDLE: if (in_accept) state_d = tfge_pkg::ST_MUL;
      tfge_pkg::ST_MUL:  state_d = tfge_pkg::ST_DIV;
      tfge_pkg::ST_DIV:  if (!div_busy) state_d = tfge_pkg::ST_FIN;
      tfge_pkg::ST_FIN:  if (out_free) state_d = tfge_pkg::ST_IDLE;
      default:           state_d = tfge_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    div_start  = 1'b0;
    commit     = 1'b0;
    case (state_q)
      tfge_pkg::ST_IDLE: in_stall_o = 1'b0;
      tfge_pkg::ST_MUL:  div_start  = 1'b1;
      tfge_pkg::ST_DIV:  commit     = 1'b0;
      tfge_pkg::ST_FIN:  commit     = out_free;
      default:           in_stall_o = 1'b1;
    endcase
  end

  // Load the output register on commit, drop it once taken
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (commit) begin
      out_valid_d      = 1'b1;
      out_d.track_echo = item_q.track;
      out_d.volume     = nx_state.cur_vol;
      out_d.playing    = nx_state.play;
      out_d.fading     = nx_state.fade;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tfge_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the accepted item and the result payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_item_i;
    end
    out_q <= out_d;
  end

  // A new result appears only out of the final sequencer step
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == tfge_pkg::ST_FIN))
    else $error("result loaded outside the final step");

  // The divider is quiet whenever the block can take an item
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tfge_pkg::ST_IDLE) |-> !div_busy)
    else $error("divider busy while idle");

  // A fading track is always a playing track
  a_fade_plays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.playing || !out_item_o.fading))
    else $error("fade reported on a stopped track");

  // Volume never exceeds the top of the gain table
  a_vol_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.volume <= 11'd1024))
    else $error("volume out of range");

endmodule

@@ rtl/tfge_serial_div.sv @@
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module tfge_serial_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [tfge_pkg::DivW-1:0]    dividend_i,
  input  logic [tfge_pkg::PosW-1:0]    divisor_i,
  output logic                         busy_o,
  output logic [tfge_pkg::DivW-1:0]    quotient_o
);

  logic [tfge_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic [tfge_pkg::PosW-1:0]    rem_q, rem_d;
  logic [tfge_pkg::DivW-1:0]    quo_q, quo_d;
  logic [tfge_pkg::PosW-1:0]    dsr_q, dsr_d;
  logic [tfge_pkg::SumW-1:0]    trial;
  logic [tfge_pkg::SumW-1:0]    diff;
  logic                         fits;

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = quo_q;

  // Shift in the next dividend bit and try to subtract the divisor
  always_comb begin
    trial = {rem_q, quo_q[tfge_pkg::DivW-1]};
    diff  = trial - {1'b0, dsr_q};
    fits  = (trial >= {1'b0, dsr_q});
    cnt_d = cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    dsr_d = dsr_q;
    if (start_i) begin
      cnt_d = tfge_pkg::DivCntW'(tfge_pkg::DivW);
      rem_d = '0;
      quo_d = dividend_i;
      dsr_d = divisor_i;
    end else if (busy_o) begin
      cnt_d = cnt_q - 1'b1;
      rem_d = fits ? diff[tfge_pkg::PosW-1:0] : trial[tfge_pkg::PosW-1:0];
      quo_d = {quo_q[tfge_pkg::DivW-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

endmodule

@@ rtl/tfge_track_regs.sv @@
// Per-track envelope state registers with one read and one write port.
`timescale 1ns / 1ps

module tfge_track_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [tfge_pkg::TrackW-1:0]    rd_idx_i,
  output tfge_pkg::track_state_t         rd_state_o,
  input  logic                           wr_en_i,
  input  logic [tfge_pkg::TrackW-1:0]    wr_idx_i,
  input  tfge_pkg::track_state_t         wr_state_i
);

  tfge_pkg::track_state_t regs_q [tfge_pkg::NumTracks];

  assign rd_state_o = regs_q[rd_idx_i];

  // Write back the committed state of one track
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tfge_pkg::NumTracks; i++) begin
        regs_q[i] <= tfge_pkg::TrackReset;
      end
    end else if (wr_en_i) begin
      regs_q[wr_idx_i] <= wr_state_i;
    end
  end

endmodule
